// File: hdl/page_framebuffer_draw_engine_defines.svh
// Assertion macros shared by the framebuffer draw engine RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PFDE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define PFDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/pfde_pkg.sv
// Package for the page framebuffer draw engine: operation codes, beat layout
// and default screen geometry. No dependencies.
package pfde_pkg;

	// Default screen geometry
	parameter int SCREEN_WIDTH_DEF  = 128;
	parameter int SCREEN_HEIGHT_DEF = 64;

	// Operation codes carried in the input tuser
	typedef enum logic [1:0] {
		FUNC_PIXEL = 2'd0,
		FUNC_BLIT  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	// Field widths
	localparam int COORD_W = 16;
	localparam int IDX_W   = 10;
	localparam int BYTE_W  = 8;
	localparam int HGT_W   = 7;

	// Input tdata layout, lowest bit first
	localparam int X_LSB     = 0;
	localparam int Y_LSB     = X_LSB + COORD_W;
	localparam int COLOR_LSB = Y_LSB + COORD_W;
	localparam int HGT_LSB   = COLOR_LSB + 1;
	localparam int IDX_LSB   = HGT_LSB + HGT_W;
	localparam int BYTE_LSB  = IDX_LSB + IDX_W;
	localparam int RADDR_LSB = BYTE_LSB + BYTE_W;
	localparam int IN_BITS   = RADDR_LSB + IDX_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

endpackage

// File: hdl/page_framebuffer_draw_engine.sv
// Top level of the page framebuffer draw engine: sequencer, divider and store.
// Depends on pfde_pkg and page_framebuffer_draw_engine_defines.svh.
//
// Monochrome framebuffer in 8-row pages, one byte per column per page, held in
// one single-port synchronous RAM of SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8)
// bytes. One operation is in flight at a time. Set pixel and blit go read,
// modify, write through the RAM's single port; read byte only reads and clear
// all only writes, one byte a cycle. An off-screen pixel makes no store access;
// a blit byte that spills into the page below gets a second read, modify, write
// there, and clipped writes are skipped. Blit first runs the one-bit-per-cycle
// divider that splits the byte index by the bitmap row count. A read of an
// address past the store skips the RAM, and every read may wait for the result
// register. After reset the same clearing pass runs, with s_tready low. A
// finished read result sits in its own output register, so a new beat is taken
// while it waits.
`include "page_framebuffer_draw_engine_defines.svh"

module page_framebuffer_draw_engine #(
	parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// x_pos[15:0], y_pos[31:16], pixel_color[32], blit_height[39:33],
	// byte_index[49:40], blit_byte[57:50], read_address[67:58], zero pad
	input  logic [pfde_pkg::IN_DATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// read_data[7:0]
	output logic [7:0]                     m_tdata
);

	localparam int PAGES   = (SCREEN_HEIGHT + 7) / 8;
	localparam int FB_SIZE = SCREEN_WIDTH * PAGES;
	localparam int AW      = $clog2(FB_SIZE);
	localparam int LW      = $clog2(FB_SIZE + SCREEN_WIDTH);
	localparam int PGW     = $clog2(PAGES + 1);
	localparam int RCW     = ((AW > pfde_pkg::IDX_W) ? AW : pfde_pkg::IDX_W) + 1;
	localparam int CNTW    = $clog2(pfde_pkg::IDX_W);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_DIV   = 8'b0000_0100,
		S_CALC  = 8'b0000_1000,
		S_ADDR  = 8'b0001_0000,
		S_RD    = 8'b0010_0000,
		S_MOD   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Operation registers
	pfde_pkg::func_t op_q;
	logic [15:0]     x_q;
	logic [15:0]     y_q;
	logic            color_q;
	logic [7:0]      byte_q;

	// Divider: dividend shifts into quotient, remainder, row count, step count
	logic [9:0]      dvd_q;
	logic [3:0]      rem_q;
	logic [4:0]      divr_q;
	logic [CNTW-1:0] div_cnt_q;
	logic [4:0]      trial;
	logic            q_bit;

	// Position and address registers
	logic [16:0]     col_q;
	logic [13:0]     page_q;
	logic [13:0]     pg1;
	logic [LW-1:0]   lin_q;
	logic [LW-1:0]   lin1;
	logic            ok0_q;
	logic            ok1_q;
	logic            pass_q;
	logic            col_ok;
	logic            pg0_ok;
	logic            pg1_ok;
	logic            y_ok;
	logic            ok0;
	logic            ok1;

	// Store
	logic [7:0]      mem [FB_SIZE];
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   mem_addr;
	logic            mem_we;
	logic [7:0]      wdata;
	logic [7:0]      rd_data_q;
	logic [15:0]     shifted;
	logic [7:0]      pix_mask;

	// Output
	logic [7:0]      pend_q;
	logic            out_valid_q;
	logic [7:0]      out_data_q;
	logic            out_free;
	logic            in_fire;
	logic            rd_in_range;
	logic [4:0]      rows;
	logic [6:0]      hgt;

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Row count of the bitmap and read range check
	assign hgt  = s_tdata[pfde_pkg::HGT_LSB +: pfde_pkg::HGT_W];
	assign rows = (hgt == 7'd0) ? 5'd1 : 5'({1'b0, 4'((hgt - 7'd1) >> 3)} + 5'd1);
	assign rd_in_range = RCW'(s_tdata[pfde_pkg::RADDR_LSB +: pfde_pkg::IDX_W])
		< RCW'(FB_SIZE);

	// One restoring division step
	always_comb begin
		trial = {rem_q, dvd_q[9]};
		q_bit = (trial >= divr_q);
	end

	// Clip checks and linear address of the page below
	always_comb begin
		pg1    = page_q + 14'd1;
		col_ok = !col_q[16] && (col_q[15:0] < 16'(SCREEN_WIDTH));
		pg0_ok = !page_q[13] && (page_q[12:0] < 13'(PAGES));
		pg1_ok = !pg1[13] && (pg1[12:0] < 13'(PAGES));
		y_ok   = !y_q[15] && (y_q[14:0] < 15'(SCREEN_HEIGHT));
		ok0    = (op_q == pfde_pkg::FUNC_PIXEL) ? (col_ok && y_ok) : (col_ok && pg0_ok);
		ok1    = (op_q == pfde_pkg::FUNC_BLIT) && col_ok && pg1_ok && (y_q[2:0] != 3'd0);
		lin1   = LW'(col_q[15:0]) + LW'(SCREEN_WIDTH) * LW'(pg1[PGW-1:0]);
	end

	// Store address, write enable and merged write data
	always_comb begin
		shifted  = {8'h00, byte_q} << y_q[2:0];
		pix_mask = 8'h01 << y_q[2:0];
		mem_we   = 1'b0;
		wdata    = 8'h00;
		if (state_q == S_CLEAR) begin
			mem_addr = clr_q;
			mem_we   = 1'b1;
		end else begin
			mem_addr = pass_q ? AW'(lin_q) : AW'(lin_q - LW'(SCREEN_WIDTH));
			if (state_q == S_MOD) begin
				case (op_q)
					pfde_pkg::FUNC_PIXEL: begin
						mem_we = 1'b1;
						wdata  = color_q ? (rd_data_q | pix_mask) : (rd_data_q & ~pix_mask);
					end
					pfde_pkg::FUNC_BLIT: begin
						mem_we = 1'b1;
						wdata  = rd_data_q | (pass_q ? shifted[15:8] : shifted[7:0]);
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
		end
	end

	// Single-port store with registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= wdata;
		rd_data_q <= mem[mem_addr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			pass_q    <= 1'b0;
			div_cnt_q <= '0;
			ok0_q     <= 1'b0;
			ok1_q     <= 1'b0;
			op_q      <= pfde_pkg::FUNC_PIXEL;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(FB_SIZE - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_fire) begin
						op_q      <= pfde_pkg::func_t'(s_tuser);
						div_cnt_q <= '0;
						unique case (pfde_pkg::func_t'(s_tuser))
							pfde_pkg::FUNC_PIXEL: state_q <= S_CALC;
							pfde_pkg::FUNC_BLIT:  state_q <= S_DIV;
							pfde_pkg::FUNC_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							pfde_pkg::FUNC_READ: begin
								pass_q  <= 1'b1;
								state_q <= rd_in_range ? S_RD : S_OUT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + CNTW'(1);
					if (div_cnt_q == CNTW'(pfde_pkg::IDX_W - 1))
						state_q <= S_CALC;
				end
				S_CALC: begin
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					ok0_q  <= ok0;
					ok1_q  <= ok1;
					pass_q <= !ok0;
					state_q <= (ok0 || ok1) ? S_RD : S_IDLE;
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (op_q == pfde_pkg::FUNC_READ) begin
						state_q <= S_OUT;
					end else if (op_q == pfde_pkg::FUNC_BLIT && !pass_q && ok1_q) begin
						pass_q  <= 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operand capture, divider steps and position math
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q     <= s_tdata[pfde_pkg::X_LSB +: pfde_pkg::COORD_W];
			y_q     <= s_tdata[pfde_pkg::Y_LSB +: pfde_pkg::COORD_W];
			color_q <= s_tdata[pfde_pkg::COLOR_LSB];
			byte_q  <= s_tdata[pfde_pkg::BYTE_LSB +: pfde_pkg::BYTE_W];
			divr_q  <= rows;
			rem_q   <= 4'd0;
			dvd_q   <= (pfde_pkg::func_t'(s_tuser) == pfde_pkg::FUNC_BLIT)
				? s_tdata[pfde_pkg::IDX_LSB +: pfde_pkg::IDX_W] : 10'd0;
			lin_q   <= LW'(s_tdata[pfde_pkg::RADDR_LSB +: pfde_pkg::IDX_W]);
			pend_q  <= 8'h00;
		end
		if (state_q == S_DIV) begin
			dvd_q <= {dvd_q[8:0], q_bit};
			rem_q <= q_bit ? 4'(trial - divr_q) : trial[3:0];
		end
		if (state_q == S_CALC) begin
			col_q  <= {x_q[15], x_q} + {7'd0, dvd_q};
			page_q <= {y_q[15], y_q[15:3]} + {10'd0, rem_q};
		end
		if (state_q == S_ADDR)
			lin_q <= lin1;
		if (state_q == S_MOD && op_q == pfde_pkg::FUNC_READ)
			pend_q <= rd_data_q;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free)
			out_data_q <= pend_q;
	end

	// Checks
	`PFDE_ASSERT_NOW(a_write_state, mem_we,
		(state_q == S_CLEAR || state_q == S_MOD), "store written outside clear or modify")
	`PFDE_ASSERT_NOW(a_blit_clip, (state_q == S_MOD && op_q == pfde_pkg::FUNC_BLIT),
		(pass_q ? ok1_q : ok0_q), "blit wrote a clipped byte")
	`PFDE_ASSERT_NOW(a_result_src, $rose(out_valid_q),
		($past(state_q) == S_OUT), "result appeared without a read")
	`PFDE_ASSERT_NEXT(a_div_done,
		(state_q == S_DIV && div_cnt_q == CNTW'(pfde_pkg::IDX_W - 1)),
		(state_q == S_CALC), "divider did not finish")

endmodule
